// File: rtl/otcg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// otcg_pkg
// Shared types, codes and the 5x8 font table of the OLED text command block.
// ----------------------------------------------------------------------------
package otcg_pkg;

	// Input command codes.
	localparam logic [3:0] CMD_PUT      = 4'd0;
	localparam logic [3:0] CMD_SETPOS   = 4'd1;
	localparam logic [3:0] CMD_CLRLINE  = 4'd2;
	localparam logic [3:0] CMD_CLRSCR   = 4'd3;
	localparam logic [3:0] CMD_CONTRAST = 4'd4;
	localparam logic [3:0] CMD_SLEEP    = 4'd5;
	localparam logic [3:0] CMD_FLIP     = 4'd6;
	localparam logic [3:0] CMD_CURSOR   = 4'd7;
	localparam logic [3:0] CMD_PAD      = 4'd8;

	// Register indexes of the configuration port.
	localparam logic REG_TALL   = 1'b0;
	localparam logic REG_OFFSET = 1'b1;

	typedef enum logic [3:0] {
		OP_PUT      = 4'd0,
		OP_SETPOS   = 4'd1,
		OP_CLRLINE  = 4'd2,
		OP_CLRSCR   = 4'd3,
		OP_CONTRAST = 4'd4,
		OP_SLEEP    = 4'd5,
		OP_FLIP     = 4'd6,
		OP_CURSOR   = 4'd7,
		OP_PAD      = 4'd8
	} op_t;

	// Result kinds.
	localparam logic [1:0] KIND_CMD   = 2'd0;
	localparam logic [1:0] KIND_GLYPH = 2'd1;
	localparam logic [1:0] KIND_FILL  = 2'd2;

	// Cursor modes, also used as glyph draw styles.
	localparam logic [1:0] CUR_OFF   = 2'd0;
	localparam logic [1:0] CUR_ON    = 2'd1;
	localparam logic [1:0] CUR_BLINK = 2'd2;

	// Controller command bytes.
	localparam logic [7:0] B_COL_LO   = 8'h00;
	localparam logic [7:0] B_COL_HI   = 8'h10;
	localparam logic [7:0] B_PAGE     = 8'hB0;
	localparam logic [7:0] B_CONTRAST = 8'h81;
	localparam logic [7:0] B_DISP_OFF = 8'hAE;
	localparam logic [7:0] B_DISP_ON  = 8'hAF;
	localparam logic [7:0] B_SEG_NORM = 8'hA0;
	localparam logic [7:0] B_SEG_REV  = 8'hA1;
	localparam logic [7:0] B_COM_NORM = 8'hC0;
	localparam logic [7:0] B_COM_REV  = 8'hC8;
	localparam logic [7:0] CURSOR_BAR = 8'h80;
	localparam logic [7:0] LINE_FILL  = 8'd128;

	localparam logic [6:0] CH_SPACE   = 7'd32;
	localparam logic [6:0] LAST_GLYPH = 7'd95;
	localparam int         GLYPH_WIDTH = 6;

	typedef struct packed {
		op_t        op;
		logic [6:0] ch;
		logic [4:0] col;
		logic [2:0] row;
		logic [7:0] val;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  cmd_byte;
		logic [47:0] glyph;
		logic [7:0]  fill;
		logic        last;
	} res_t;

	// Five columns per glyph, first column in the high byte.
	localparam logic [39:0] FONT_ROM [96] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
		40'h242A7F2A12, 40'h2313086462, 40'h3649562050, 40'h0008070300,
		40'h001C224100, 40'h0041221C00, 40'h2A1C7F1C2A, 40'h08083E0808,
		40'h0080703000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
		40'h3649494936, 40'h464949291E, 40'h0000140000, 40'h0040340000,
		40'h0008142241, 40'h1414141414, 40'h0041221408, 40'h0201590906,
		40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41415173,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h2649494932,
		40'h03017F0103, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
		40'h6314081463, 40'h0304780403, 40'h6159494D43, 40'h007F414141,
		40'h0204081020, 40'h004141417F, 40'h0402010204, 40'h4040404040,
		40'h0003070800, 40'h2054547840, 40'h7F28444438, 40'h3844444428,
		40'h384444287F, 40'h3854545418, 40'h00087E0902, 40'h18A4A49C78,
		40'h7F08040478, 40'h00447D4000, 40'h2040403D00, 40'h7F10284400,
		40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
		40'hFC18242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545424,
		40'h04043F4424, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
		40'h4428102844, 40'h4C9090907C, 40'h4464544C44, 40'h0008364100,
		40'h0000770000, 40'h0041360800, 40'h0201020402, 40'h3C2623263C
	};

	// Six glyph columns, first column in the low byte; the sixth is blank before the style is applied.
	function automatic logic [47:0] glyph_bits(input logic [6:0] g, input logic [1:0] style);
		logic [6:0]  gi;
		logic [7:0]  b;
		logic [47:0] v;
		gi = (g > LAST_GLYPH) ? 7'd0 : g;
		v  = '0;
		for (int i = 0; i < 6; i++) begin
			b = (i < 5) ? FONT_ROM[gi][8*(4-i) +: 8] : 8'h00;
			if (style == CUR_ON) begin
				b = b | CURSOR_BAR;
			end else if (style == CUR_BLINK) begin
				b = ~b;
			end
			v[8*i +: 8] = b;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

// File: rtl/otcg_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// otcg_fifo
// Two-entry queue with registered storage and no fall-through.
// ----------------------------------------------------------------------------
module otcg_fifo #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              full,
	output logic              empty
);

	logic [W-1:0] data_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = data_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop) rp_q <= ~rp_q;
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) data_q[wp_q] <= wdata;
	end

endmodule
`default_nettype wire

// File: rtl/otcg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// otcg_front
// Accepts text commands, drops invalid ones (bad position, row, cursor mode or code), and queues the rest.
// ----------------------------------------------------------------------------
module otcg_front
	import otcg_pkg::*;
#(
	parameter int TEXT_COLS     = 21,
	parameter int MAX_TEXT_ROWS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [3:0] cmd,
	input  wire logic [7:0] char_code,
	input  wire logic [4:0] column,
	input  wire logic [2:0] row,
	input  wire logic [7:0] value,
	input  wire logic       tall,
	input  wire logic       q_pop,
	output cmd_t            q_data,
	output logic            q_empty
);

	cmd_t       dec;
	logic       keep;
	logic [3:0] act_rows;
	logic [$bits(cmd_t)-1:0] q_bits;

	assign act_rows = tall ? 4'(MAX_TEXT_ROWS) : 4'd4;

	always_comb begin
		dec.op  = OP_PUT;
		dec.ch  = (char_code[7] || char_code[6:5] == 2'b00) ? CH_SPACE : char_code[6:0];
		dec.col = column;
		dec.row = row;
		dec.val = value;
		keep    = 1'b1;
		unique case (cmd)
			CMD_PUT:      dec.op = OP_PUT;
			CMD_SETPOS: begin
				dec.op = OP_SETPOS;
				keep   = (6'(column) < 6'(TEXT_COLS)) && ({1'b0, row} < act_rows);
			end
			CMD_CLRLINE: begin
				dec.op = OP_CLRLINE;
				keep   = {1'b0, row} < act_rows;
			end
			CMD_CLRSCR:   dec.op = OP_CLRSCR;
			CMD_CONTRAST: dec.op = OP_CONTRAST;
			CMD_SLEEP:    dec.op = OP_SLEEP;
			CMD_FLIP:     dec.op = OP_FLIP;
			CMD_CURSOR: begin
				dec.op = OP_CURSOR;
				keep   = value <= 8'd2;
			end
			CMD_PAD:      dec.op = OP_PAD;
			default:      keep = 1'b0;
		endcase
	end

	otcg_fifo #(.W($bits(cmd_t))) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push && !full && keep),
		.wdata (dec),
		.pop   (q_pop),
		.rdata (q_bits),
		.full  (full),
		.empty (q_empty)
	);

	assign q_data = cmd_t'(q_bits);

endmodule
`default_nettype wire

// File: rtl/otcg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// otcg_back
// Sequencer: queued commands to controller results, at most one a cycle.
// ----------------------------------------------------------------------------
module otcg_back
	import otcg_pkg::*;
#(
	parameter int TEXT_COLS     = 21,
	parameter int MAX_TEXT_ROWS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       tall,
	input  wire logic [2:0] col_off,
	input  wire logic       q_empty,
	input  wire cmd_t       q_data,
	output logic            q_pop,
	input  wire logic       oq_full,
	output logic            res_push,
	output res_t            res_out
);

	localparam int DEPTH  = TEXT_COLS * MAX_TEXT_ROWS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_ATGT  = 13'b0000000000010,
		ST_ASAV1 = 13'b0000000000100,
		ST_OFFG  = 13'b0000000001000,
		ST_ACUR  = 13'b0000000010000,
		ST_RD    = 13'b0000000100000,
		ST_SHOWG = 13'b0000001000000,
		ST_ASAV2 = 13'b0000010000000,
		ST_FILL  = 13'b0000100000000,
		ST_PUT   = 13'b0001000000000,
		ST_CLS   = 13'b0010000000000,
		ST_BYTE  = 13'b0100000000000,
		ST_DONE  = 13'b1000000000000
	} state_t;

	state_t      st_q;
	logic [1:0]  sub_q;
	logic [5:0]  k_q;
	op_t         op_q;
	logic [6:0]  ch_q;
	logic [4:0]  tcol_q;
	logic [2:0]  trow_q;
	logic [7:0]  val_q;
	logic        pass_q;
	logic [1:0]  style_q;
	logic [1:0]  mode_q;
	logic [4:0]  wcol_q;
	logic [2:0]  wrow_q;
	logic [4:0]  scol_q;
	logic [2:0]  srow_q;
	logic [6:0]  sglyph_q;
	res_t        hold_q;
	logic        hold_v_q;
	logic [6:0]  mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [6:0]  rd_q;
	logic        rd_v_q;

	logic        adv;
	logic [3:0]  act_rows;
	logic        cur_ok;
	logic [4:0]  ccol;
	logic [2:0]  crow;
	logic [ADDR_W-1:0] caddr;
	logic [4:0]  a_col;
	logic [2:0]  a_row;
	logic [7:0]  p;
	logic [7:0]  addr_byte;
	logic [6:0]  g_rd;
	logic [5:0]  pgk;
	logic        cls_last;
	logic [7:0]  cls_byte;
	logic        emit;
	res_t        nres;
	state_t      pos_next;
	logic        pos_clr;
	logic        wrap_col;
	logic [3:0]  row_inc;
	logic        clr_row;
	logic        clr_all;
	logic        do_put;

	assign adv      = !oq_full;
	assign act_rows = tall ? 4'(MAX_TEXT_ROWS) : 4'd4;
	assign cur_ok   = {1'b0, wrow_q} < act_rows;
	assign ccol     = cur_ok ? wcol_q : 5'd0;
	assign crow     = cur_ok ? wrow_q : 3'd0;
	assign caddr    = ADDR_W'(8'(crow) * 8'(TEXT_COLS) + 8'(ccol));
	assign q_pop    = adv && (st_q == ST_IDLE) && !q_empty;
	assign g_rd     = rd_v_q ? (rd_q - CH_SPACE) : 7'd0;

	// Column and page address bytes of a text cell.
	always_comb begin
		a_col = scol_q;
		a_row = srow_q;
		if (st_q == ST_ATGT) begin
			a_col = tcol_q;
			a_row = trow_q;
		end else if (st_q == ST_ACUR) begin
			a_col = ccol;
			a_row = crow;
		end
		p = 8'(a_col) * 8'(GLYPH_WIDTH) + 8'(col_off);
		unique case (sub_q)
			2'd0:    addr_byte = B_COL_LO | {4'h0, p[3:0]};
			2'd1:    addr_byte = B_COL_HI | {4'h0, p[7:4]};
			default: addr_byte = B_PAGE | {5'd0, a_row};
		endcase
	end

	// Clear screen walks pages of four results and ends with a home address.
	always_comb begin
		pgk      = tall ? 6'd32 : 6'd16;
		cls_last = (k_q == pgk + 6'd2);
		unique case (k_q[1:0])
			2'd0:    cls_byte = B_COL_LO | {5'd0, col_off};
			2'd1:    cls_byte = B_COL_HI;
			2'd2:    cls_byte = B_PAGE | ((k_q < pgk) ? {5'd0, k_q[4:2]} : 8'd0);
			default: cls_byte = 8'd0;
		endcase
	end

	always_comb begin
		emit = 1'b0;
		nres = '0;
		unique case (st_q)
			ST_ATGT, ST_ASAV1, ST_ACUR, ST_ASAV2: begin
				emit          = 1'b1;
				nres.kind     = KIND_CMD;
				nres.cmd_byte = addr_byte;
			end
			ST_OFFG: begin
				emit       = 1'b1;
				nres.kind  = KIND_GLYPH;
				nres.glyph = glyph_bits(sglyph_q, CUR_OFF);
			end
			ST_SHOWG: begin
				emit       = 1'b1;
				nres.kind  = KIND_GLYPH;
				nres.glyph = glyph_bits(g_rd, style_q);
			end
			ST_FILL: begin
				emit      = 1'b1;
				nres.kind = KIND_FILL;
				nres.fill = LINE_FILL;
			end
			ST_PUT: begin
				emit       = 1'b1;
				nres.kind  = KIND_GLYPH;
				nres.glyph = glyph_bits(ch_q - CH_SPACE, CUR_OFF);
			end
			ST_CLS: begin
				emit = 1'b1;
				if (k_q[1:0] == 2'd3) begin
					nres.kind = KIND_FILL;
					nres.fill = LINE_FILL + 8'(col_off);
				end else begin
					nres.kind     = KIND_CMD;
					nres.cmd_byte = cls_byte;
				end
			end
			ST_BYTE: begin
				emit      = 1'b1;
				nres.kind = KIND_CMD;
				if (op_q == OP_CONTRAST) begin
					nres.cmd_byte = (k_q == 6'd0) ? B_CONTRAST : val_q;
				end else if (op_q == OP_SLEEP) begin
					nres.cmd_byte = (val_q != 8'd0) ? B_DISP_OFF : B_DISP_ON;
				end else if (val_q != 8'd0) begin
					nres.cmd_byte = (k_q == 6'd0) ? B_SEG_NORM : B_COM_NORM;
				end else begin
					nres.cmd_byte = (k_q == 6'd0) ? B_SEG_REV : B_COM_REV;
				end
			end
			default: emit = 1'b0;
		endcase
	end

	// The newest result waits in a hold register until the next one or the end
	// of the command shows whether it is the final one.
	always_comb begin
		res_push = 1'b0;
		res_out  = hold_q;
		if (adv && hold_v_q) begin
			if (emit) begin
				res_push     = 1'b1;
				res_out.last = 1'b0;
			end else if (st_q == ST_DONE) begin
				res_push     = 1'b1;
				res_out.last = 1'b1;
			end
		end
	end

	always_comb begin
		pos_clr  = (op_q == OP_CLRLINE) && pass_q;
		pos_next = ((op_q == OP_CLRLINE) && !pass_q) ? ST_FILL : ST_DONE;
	end

	assign wrap_col = (6'(ccol) + 6'd1) == 6'(TEXT_COLS);
	assign row_inc  = {1'b0, crow} + 4'd1;
	assign do_put   = adv && (st_q == ST_PUT);
	assign clr_all  = adv && (st_q == ST_CLS) && cls_last;
	assign clr_row  = adv && pos_clr && (sub_q == 2'd2) &&
		(((st_q == ST_ATGT) && (mode_q == CUR_OFF)) || (st_q == ST_ASAV2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			sub_q    <= 2'd0;
			k_q      <= 6'd0;
			op_q     <= OP_PUT;
			pass_q   <= 1'b0;
			style_q  <= CUR_OFF;
			mode_q   <= CUR_OFF;
			wcol_q   <= 5'd0;
			wrow_q   <= 3'd0;
			scol_q   <= 5'd0;
			srow_q   <= 3'd0;
			sglyph_q <= 7'd0;
			hold_v_q <= 1'b0;
		end else if (adv) begin
			if (emit) hold_v_q <= 1'b1;
			unique case (st_q)
				ST_IDLE: begin
					if (!q_empty) begin
						op_q   <= q_data.op;
						pass_q <= 1'b0;
						sub_q  <= 2'd0;
						// Put char draws one cell, pad line the rest of the row.
						k_q    <= (q_data.op == OP_PUT) ? 6'd1 :
							(q_data.op == OP_PAD) ? (6'(TEXT_COLS) - 6'(ccol)) : 6'd0;
						unique case (q_data.op)
							OP_PUT, OP_PAD: st_q <= ST_PUT;
							OP_SETPOS, OP_CLRLINE: st_q <= ST_ATGT;
							OP_CLRSCR: st_q <= ST_CLS;
							OP_CONTRAST, OP_SLEEP, OP_FLIP: st_q <= ST_BYTE;
							OP_CURSOR: begin
								if (q_data.val[1:0] != mode_q) begin
									mode_q  <= q_data.val[1:0];
									style_q <= q_data.val[1:0];
									st_q    <= (q_data.val[1:0] == CUR_OFF) ? ST_ASAV1 : ST_RD;
								end else begin
									st_q <= ST_DONE;
								end
							end
							default: st_q <= ST_DONE;
						endcase
					end
				end
				ST_ATGT: begin
					if (sub_q == 2'd2) begin
						sub_q  <= 2'd0;
						wcol_q <= tcol_q;
						wrow_q <= trow_q;
						if (mode_q != CUR_OFF) begin
							style_q <= mode_q;
							st_q    <= ST_ASAV1;
						end else begin
							st_q <= pos_next;
						end
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
				ST_ASAV1: begin
					if (sub_q == 2'd2) begin
						sub_q <= 2'd0;
						st_q  <= ST_OFFG;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
				ST_OFFG: st_q <= ST_ACUR;
				ST_ACUR: begin
					if (sub_q == 2'd2) begin
						sub_q <= 2'd0;
						st_q  <= (op_q == OP_CURSOR) ? ST_DONE : ST_RD;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
				ST_RD: st_q <= ST_SHOWG;
				ST_SHOWG: begin
					scol_q   <= ccol;
					srow_q   <= crow;
					sglyph_q <= g_rd;
					st_q     <= ST_ASAV2;
				end
				ST_ASAV2: begin
					if (sub_q == 2'd2) begin
						sub_q <= 2'd0;
						st_q  <= (op_q == OP_CURSOR) ? ST_DONE : pos_next;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
				ST_FILL: begin
					pass_q <= 1'b1;
					st_q   <= ST_ATGT;
				end
				ST_PUT: begin
					k_q <= k_q - 6'd1;
					if (wrap_col) begin
						wcol_q <= 5'd0;
						wrow_q <= (row_inc >= act_rows) ? 3'd0 : row_inc[2:0];
					end else begin
						wcol_q <= ccol + 5'd1;
						wrow_q <= crow;
					end
					if (k_q == 6'd1) st_q <= ST_DONE;
				end
				ST_CLS: begin
					k_q <= k_q + 6'd1;
					if (cls_last) begin
						wcol_q <= 5'd0;
						wrow_q <= 3'd0;
						st_q   <= ST_DONE;
					end
				end
				ST_BYTE: begin
					k_q <= k_q + 6'd1;
					if (op_q == OP_SLEEP || k_q == 6'd1) st_q <= ST_DONE;
				end
				ST_DONE: begin
					hold_v_q <= 1'b0;
					st_q     <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers of the sequencer.
	always_ff @(posedge clk) begin
		if (adv && emit) hold_q <= nres;
		if (q_pop) begin
			ch_q   <= (q_data.op == OP_PAD) ? CH_SPACE : q_data.ch;
			val_q  <= q_data.val;
			tcol_q <= (q_data.op == OP_CLRLINE) ? 5'd0 : q_data.col;
			trow_q <= q_data.row;
		end
	end

	// Character store: an entry without its valid bit reads as a space.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (do_put) valid_q[caddr] <= 1'b1;
			for (int e = 0; e < DEPTH; e++) begin
				if (clr_row && (e / TEXT_COLS) == int'(trow_q)) valid_q[e] <= 1'b0;
				if (clr_all && (e / TEXT_COLS) < int'(act_rows)) valid_q[e] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_put) mem_q[caddr] <= ch_q;
		rd_q   <= mem_q[caddr];
		rd_v_q <= valid_q[caddr];
	end

endmodule
`default_nettype wire

// File: rtl/oled_text_command_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oled_text_command_generator
// Text commands in, page-addressed OLED controller transfer stream out.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Fields
//   -------   ----------------   ------------------------------------------
//   input     push / full        cmd, char_code, column, row, value
//   result    empty / pop        kind, command_byte, glyph_columns,
//                                fill_length, last
//   config    cfg_write          cfg_index, cfg_data
//
// Each request is classified and queued on the input side; the sequencer
// loads it, produces one result per cycle while the result queue has room,
// and closes the command; a cursor redraw adds a character store read.
// Reset clears the store at once through per-entry valid bits; no sweep.
// A full result queue stalls only the sequencer; the input side keeps
// taking requests until its two-entry command queue is full.
//
module oled_text_command_generator
	import otcg_pkg::*;
#(
	parameter int TEXT_COLS     = 21,
	parameter int MAX_TEXT_ROWS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [3:0]  cmd,
	input  wire logic [7:0]  char_code,
	input  wire logic [4:0]  column,
	input  wire logic [2:0]  row,
	input  wire logic [7:0]  value,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       kind,
	output logic [7:0]       command_byte,
	output logic [47:0]      glyph_columns,
	output logic [7:0]       fill_length,
	output logic             last,
	input  wire logic        cfg_write,
	input  wire logic        cfg_index,
	input  wire logic [2:0]  cfg_data
);

	logic       tall_q;
	logic [2:0] col_off_q;
	cmd_t       q_data;
	logic       q_empty;
	logic       q_pop;
	logic       oq_full;
	logic       res_push;
	res_t       res_in;
	res_t       res_head;
	logic [$bits(res_t)-1:0] res_bits;

	// Configuration must only be written while the block is idle; it is not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tall_q    <= 1'b1;
			col_off_q <= 3'd0;
		end else if (cfg_write) begin
			if (cfg_index == REG_TALL) begin
				tall_q <= cfg_data[0];
			end else if (cfg_index == REG_OFFSET) begin
				col_off_q <= cfg_data;
			end
		end
	end

	// Front: classification and the command queue.
	otcg_front #(
		.TEXT_COLS    (TEXT_COLS),
		.MAX_TEXT_ROWS(MAX_TEXT_ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.cmd      (cmd),
		.char_code(char_code),
		.column   (column),
		.row      (row),
		.value    (value),
		.tall     (tall_q),
		.q_pop    (q_pop),
		.q_data   (q_data),
		.q_empty  (q_empty)
	);

	// Back: the result sequencer with the character store and cursor state.
	otcg_back #(
		.TEXT_COLS    (TEXT_COLS),
		.MAX_TEXT_ROWS(MAX_TEXT_ROWS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.tall    (tall_q),
		.col_off (col_off_q),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.oq_full (oq_full),
		.res_push(res_push),
		.res_out (res_in)
	);

	// Result queue that parts the sequencer from the consumer.
	otcg_fifo #(.W($bits(res_t))) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.pop   (pop),
		.rdata (res_bits),
		.full  (oq_full),
		.empty (empty)
	);

	assign res_head      = res_t'(res_bits);
	assign kind          = res_head.kind;
	assign command_byte  = res_head.cmd_byte;
	assign glyph_columns = res_head.glyph;
	assign fill_length   = res_head.fill;
	assign last          = res_head.last;

endmodule
`default_nettype wire
